@@ rtl/core/rmx_pkg.sv @@
// shared constants and codes for the range max-xor versioned trie
package rmx_pkg;

    // field widths of the item ports
    localparam int KIND_W     = 1;
    localparam int VALUE_W    = 30;
    localparam int POS_W      = 10;
    localparam int STATUS_W   = 2;

    // default sizes
    localparam int VALUE_BITS_DEF = 30;
    localparam int MAX_ITEMS_DEF  = 1024;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_APPEND = 1'b0;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

endpackage

@@ rtl/core/rmx_in_if.sv @@
// request channel: append or range query
interface rmx_in_if;
    logic                        valid;
    logic                        ready;
    logic [rmx_pkg::KIND_W-1:0]  kind;
    logic [rmx_pkg::VALUE_W-1:0] value;
    logic [rmx_pkg::POS_W-1:0]   first_pos;
    logic [rmx_pkg::POS_W-1:0]   last_pos;

    modport source (output valid, kind, value, first_pos, last_pos, input ready);
    modport sink   (input valid, kind, value, first_pos, last_pos, output ready);
endinterface

@@ rtl/core/rmx_out_if.sv @@
// result channel
interface rmx_out_if;
    logic                         valid;
    logic                         ready;
    logic [rmx_pkg::VALUE_W-1:0]  max_xor;
    logic [rmx_pkg::POS_W-1:0]    position;
    logic [rmx_pkg::STATUS_W-1:0] status;

    modport source (output valid, max_xor, position, status, input ready);
    modport sink   (input valid, max_xor, position, status, output ready);
endinterface

@@ rtl/core/rmx_cell.sv @@
// one trie level: node store indexed by version, walks one bit per cycle
module rmx_cell #(
    parameter int VALUE_BITS = rmx_pkg::VALUE_BITS_DEF,
    parameter int MAX_ITEMS  = rmx_pkg::MAX_ITEMS_DEF,
    parameter int LEVEL      = 0
) (
    input  logic clk,
    input  logic rst_n,
    input  logic [2*VALUE_BITS+3*$clog2(MAX_ITEMS)+3:0] tok_above,
    output logic [2*VALUE_BITS+3*$clog2(MAX_ITEMS)+3:0] tok_below
);
    localparam int IW  = $clog2(MAX_ITEMS);
    localparam int CW  = $clog2(MAX_ITEMS + 1);
    localparam int BIT = VALUE_BITS - 1 - LEVEL;

    typedef struct packed {
        logic                  valid;
        logic                  kind;
        logic [VALUE_BITS-1:0] key;
        logic [IW-1:0]         pos;
        logic [VALUE_BITS-1:0] res;
        logic                  l_ok;
        logic [IW-1:0]         l_idx;
        logic                  r_ok;
        logic [IW-1:0]         r_idx;
    } tok_t;

    typedef struct packed {
        logic          ok;
        logic [IW-1:0] idx;
    } ptr_t;

    typedef struct packed {
        ptr_t          c1;
        ptr_t          c0;
        logic [CW-1:0] n1;
        logic [CW-1:0] n0;
    } node_t;

    node_t mem [MAX_ITEMS];

    tok_t  tin;
    tok_t  tok_reg;
    tok_t  tout;
    node_t rd_l_reg;
    node_t rd_r_reg;
    node_t el;
    node_t er;
    node_t wr_node;
    logic  bitv;
    logic  want;
    logic  pick;
    logic  wr_en;
    logic [CW-1:0] cl;
    logic [CW-1:0] cr;

    assign tin = tok_t'(tok_above);

    // token moves in with the node reads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tin;
        end
    end

    // node store: two reads, one write at the new version
    always_ff @(posedge clk)
    begin
        rd_l_reg <= mem[tin.l_idx];
        rd_r_reg <= mem[tin.r_idx];
        if (wr_en)
        begin
            mem[tok_reg.pos] <= wr_node;
        end
    end

    // empty node reads as all zero
    assign el   = tok_reg.l_ok ? rd_l_reg : '0;
    assign er   = tok_reg.r_ok ? rd_r_reg : '0;
    assign bitv = tok_reg.key[BIT];
    assign want = ~bitv;
    assign cr   = want ? er.n1 : er.n0;
    assign cl   = want ? el.n1 : el.n0;
    assign pick = (cr > cl) ? want : bitv;
    assign wr_en = tok_reg.valid && (tok_reg.kind == rmx_pkg::KIND_APPEND);

    // copy of the source node with the taken branch pointing at the new path
    always_comb
    begin
        wr_node = er;
        if (bitv)
        begin
            wr_node.c1 = '{ok: 1'b1, idx: tok_reg.pos};
            wr_node.n1 = er.n1 + CW'(1);
        end
        else
        begin
            wr_node.c0 = '{ok: 1'b1, idx: tok_reg.pos};
            wr_node.n0 = er.n0 + CW'(1);
        end
    end

    // token for the next level
    always_comb
    begin
        tout = tok_reg;
        if (tok_reg.kind == rmx_pkg::KIND_APPEND)
        begin
            {tout.r_ok, tout.r_idx} = bitv ? er.c1 : er.c0;
        end
        else
        begin
            if (cr > cl)
            begin
                tout.res[BIT] = 1'b1;
            end
            {tout.l_ok, tout.l_idx} = pick ? el.c1 : el.c0;
            {tout.r_ok, tout.r_idx} = pick ? er.c1 : er.c0;
        end
    end

    assign tok_below = tout;

endmodule

@@ rtl/core/range_max_xor_versioned_trie.sv @@
// Timing: a refused request answers in the cycle after its transfer; an append or
// a query runs the chain, one trie level per cell, then the result register.
// Flow: one item at a time, a new request is taken only once the result is
// taken; each cell does two synchronous node reads.
// Reset: the item count clears and the chain empties; node stores are not
// cleared, every node read that is used was written by an earlier append.
module range_max_xor_versioned_trie #(
    parameter int VALUE_BITS = rmx_pkg::VALUE_BITS_DEF,
    parameter int MAX_ITEMS  = rmx_pkg::MAX_ITEMS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    rmx_in_if.sink    req,
    rmx_out_if.source rsp
);
    localparam int IW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int TW = 2*VALUE_BITS + 3*IW + 4;

    typedef struct packed {
        logic                  valid;
        logic                  kind;
        logic [VALUE_BITS-1:0] key;
        logic [IW-1:0]         pos;
        logic [VALUE_BITS-1:0] res;
        logic                  l_ok;
        logic [IW-1:0]         l_idx;
        logic                  r_ok;
        logic [IW-1:0]         r_idx;
    } tok_t;

    logic [TW-1:0] chain [VALUE_BITS+1];

    logic [CW-1:0] item_total_reg;
    logic [CW-1:0] item_total_next;
    logic          busy_reg;
    logic          busy_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [rmx_pkg::VALUE_W-1:0]  max_xor_reg;
    logic [rmx_pkg::VALUE_W-1:0]  max_xor_next;
    logic [rmx_pkg::POS_W-1:0]    position_reg;
    logic [rmx_pkg::POS_W-1:0]    position_next;
    logic [rmx_pkg::STATUS_W-1:0] status_reg;
    logic [rmx_pkg::STATUS_W-1:0] status_next;

    logic accept;
    logic out_xfer;
    logic is_append;
    logic full;
    logic bad_range;
    logic refuse;
    tok_t launch;
    tok_t done;

    assign accept    = req.valid && req.ready;
    assign out_xfer  = rsp.valid && rsp.ready;
    assign is_append = (req.kind == rmx_pkg::KIND_APPEND);
    assign full      = (item_total_reg == CW'(MAX_ITEMS));
    assign bad_range = (req.first_pos > req.last_pos) ||
                       (32'(req.last_pos) >= 32'(item_total_reg));
    assign refuse    = is_append ? full : bad_range;
    assign req.ready = !busy_reg;

    // start token for the first level
    always_comb
    begin
        launch       = '0;
        launch.valid = accept && !refuse;
        launch.kind  = req.kind;
        launch.key   = VALUE_BITS'(req.value);
        launch.pos   = IW'(item_total_reg);
        if (is_append)
        begin
            launch.r_ok  = (item_total_reg != '0);
            launch.r_idx = IW'(item_total_reg - CW'(1));
        end
        else
        begin
            launch.l_ok  = (req.first_pos != '0);
            launch.l_idx = IW'(req.first_pos - rmx_pkg::POS_W'(1));
            launch.r_ok  = 1'b1;
            launch.r_idx = IW'(req.last_pos);
        end
    end

    assign chain[0] = launch;

    // one cell per trie level, top bit first
    for (genvar g = 0; g < VALUE_BITS; g++)
    begin : g_cell
        rmx_cell #(
            .VALUE_BITS (VALUE_BITS),
            .MAX_ITEMS  (MAX_ITEMS),
            .LEVEL      (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .tok_above (chain[g]),
            .tok_below (chain[g+1])
        );
    end

    assign done = tok_t'(chain[VALUE_BITS]);

    // control and result register
    always_comb
    begin
        item_total_next = item_total_reg;
        busy_next       = busy_reg;
        out_valid_next  = out_valid_reg;
        max_xor_next    = max_xor_reg;
        position_next   = position_reg;
        status_next     = status_reg;
        if (out_xfer)
        begin
            out_valid_next = 1'b0;
            busy_next      = 1'b0;
        end
        if (accept)
        begin
            busy_next = 1'b1;
            if (refuse)
            begin
                out_valid_next = 1'b1;
                max_xor_next   = '0;
                position_next  = '0;
                status_next    = is_append ? rmx_pkg::ST_FULL : rmx_pkg::ST_RANGE;
            end
            else if (is_append)
            begin
                item_total_next = item_total_reg + CW'(1);
            end
        end
        if (done.valid)
        begin
            out_valid_next = 1'b1;
            status_next    = rmx_pkg::ST_OK;
            if (done.kind == rmx_pkg::KIND_APPEND)
            begin
                max_xor_next  = '0;
                position_next = rmx_pkg::POS_W'(done.pos);
            end
            else
            begin
                max_xor_next  = rmx_pkg::VALUE_W'(done.res);
                position_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_total_reg <= '0;
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_total_reg <= item_total_next;
            busy_reg       <= busy_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        max_xor_reg  <= max_xor_next;
        position_reg <= position_next;
        status_reg   <= status_next;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.max_xor  = max_xor_reg;
    assign rsp.position = position_reg;
    assign rsp.status   = status_reg;

`ifndef SYNTHESIS
    // count never passes the store size
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        item_total_reg <= CW'(MAX_ITEMS))
        else $error("item count over store size");

    // nothing leaves the chain while idle
    a_idle_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> !done.valid)
        else $error("chain output while idle");

    // accepted append grows the count by one
    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_append && !full) |=> item_total_reg == $past(item_total_reg) + CW'(1))
        else $error("append did not advance count");

    // no result shows when an item leaves the chain
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        done.valid |-> !out_valid_reg)
        else $error("result overlap");
`endif

endmodule
